[hdl/hcp_pkg.sv]
// Shared constants and types for the Huffman code table bit packer.
package hcp_pkg;

   // Item kinds carried in the input selector.
   typedef enum logic [1:0] {
      MODE_LOAD   = 2'd0,
      MODE_ENCODE = 2'd1,
      MODE_FINISH = 2'd2
   } mode_type;

   localparam int BYTE_W           = 8;
   localparam int SYMBOL_W         = 8;
   localparam int CODE_FIELD_W     = 32;
   localparam int LENGTH_FIELD_W   = 6;
   localparam int TABLE_DEPTH      = 256;
   localparam int MAX_CODE_LEN_DEF = 32;
   localparam int QUEUE_DEPTH_DEF  = 4;

endpackage

[hdl/huffman_code_table_bit_packer_top.sv]
// Top level of the Huffman code table bit packer.
//
// Byte-stream Huffman encoder. Each input transfer carries a kind in req_tuser:
// load writes one of 256 code table entries (code right aligned, length
// saturated to min(MAX_CODE_LEN, 32), bits above the length dropped), encode
// appends the code of a byte MSB first to a bit accumulator, finish appends the
// code of the csr-configured end-of-stream symbol, pads with zeros to a byte
// boundary and flags the final byte with rsp_tlast. Each full byte leaves as one
// output transfer, first code bit in bit 7. A finish with nothing left to flush
// gives no transfer; kind 3 is dropped. Read only table entries that were
// loaded. Timing: the front accepts one transfer per cycle while the queue
// (QUEUE_DEPTH entries, 4 by default) has room, so loads and short bursts go
// at full rate. For each encode or finish the back end first merges the
// looked-up code into the accumulator, then sends out each full byte (for a
// finish, also the padded tail) before it takes the next item: at most four
// full bytes per item; the output register sets the pace of one byte per cycle
// while rsp_tready is high. A lookup goes through the table RAM's registered
// read and reaches the queue in the cycle after the item is accepted. There
// is no clearing pass. Write csr_wdata only while the block is idle.
module huffman_code_table_bit_packer_top #(
   parameter int MAX_CODE_LEN = hcp_pkg::MAX_CODE_LEN_DEF,
   parameter int QUEUE_DEPTH  = hcp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // symbol[7:0], code_bits[39:8], code_length[45:40], zero
   input  logic [1:0]  req_tuser,  // mode[1:0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // out_byte[7:0]
   output logic        rsp_tlast,  // last
   // configuration: end-of-stream symbol
   input  logic        csr_wen,
   input  logic [7:0]  csr_wdata
);

   import hcp_pkg::*;

   localparam int LEN_LIMIT = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
   localparam int LEN_W     = $clog2(LEN_LIMIT + 1);
   localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);
   localparam int QENT_W    = LEN_LIMIT + LEN_W + 1;

   logic                      push;
   logic [LEN_LIMIT-1:0]      push_code;
   logic [LEN_W-1:0]          push_len;
   logic                      push_fin;
   logic [QCNT_W-1:0]         queue_count;
   logic                      q_valid;
   logic                      q_pop;
   logic [QENT_W-1:0]         q_data;

   // Unpack the input payload.
   hcp_front #(
      .MAX_CODE_LEN (MAX_CODE_LEN),
      .QUEUE_DEPTH  (QUEUE_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .mode        (req_tuser),
      .symbol      (req_tdata[7:0]),
      .code_bits   (req_tdata[39:8]),
      .code_length (req_tdata[45:40]),
      .csr_wen     (csr_wen),
      .csr_wdata   (csr_wdata),
      .queue_count (queue_count),
      .push        (push),
      .push_code   (push_code),
      .push_len    (push_len),
      .push_fin    (push_fin)
   );

   // Decouple lookup from packing so either side can stall.
   hcp_queue #(
      .WIDTH (QENT_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_fin, push_len, push_code}),
      .pop       (q_pop),
      .pop_data  (q_data),
      .not_empty (q_valid),
      .count     (queue_count)
   );

   hcp_back #(
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_code    (q_data[LEN_LIMIT-1:0]),
      .q_len     (q_data[LEN_LIMIT +: LEN_W]),
      .q_fin     (q_data[QENT_W-1]),
      .q_pop     (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_byte  (rsp_tdata),
      .rsp_last  (rsp_tlast)
   );

endmodule

[hdl/hcp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module hcp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wen,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wen) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[hdl/hcp_queue.sv]
// Small register FIFO between the lookup front and the packing back end.
module hcp_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty,
   output logic [CNT_W-1:0] count
);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data  = slot_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign count     = count_ff;

endmodule

[hdl/hcp_front.sv]
// Front end: accepts items, writes the code table, looks up codes for the queue.
module hcp_front #(
   parameter int MAX_CODE_LEN = hcp_pkg::MAX_CODE_LEN_DEF,
   parameter int QUEUE_DEPTH  = hcp_pkg::QUEUE_DEPTH_DEF,
   localparam int LEN_LIMIT = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32,
   localparam int LEN_W     = $clog2(LEN_LIMIT + 1),
   localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           mode,
   input  logic [hcp_pkg::SYMBOL_W-1:0]         symbol,
   input  logic [hcp_pkg::CODE_FIELD_W-1:0]     code_bits,
   input  logic [hcp_pkg::LENGTH_FIELD_W-1:0]   code_length,
   input  logic                                 csr_wen,
   input  logic [hcp_pkg::SYMBOL_W-1:0]         csr_wdata,
   input  logic [QCNT_W-1:0]                    queue_count,
   output logic                                 push,
   output logic [LEN_LIMIT-1:0]                 push_code,
   output logic [LEN_W-1:0]                     push_len,
   output logic                                 push_fin
);

   import hcp_pkg::*;

   localparam int ENTRY_W = LEN_LIMIT + LEN_W;

   mode_type              item_mode;
   logic                  accept;
   logic                  ram_wen;
   logic [SYMBOL_W-1:0]   ram_raddr;
   logic [LEN_W-1:0]      len_sat;
   logic [LEN_LIMIT-1:0]  code_masked;
   logic [ENTRY_W-1:0]    ram_rdata;
   logic [SYMBOL_W-1:0]   eof_ff, eof_in;
   logic                  lkp_vld_ff, lkp_vld_in;
   logic                  lkp_fin_ff, lkp_fin_in;
   logic [QCNT_W:0]       committed;

   assign item_mode = mode_type'(mode);

   // Hold off while queued plus in-flight lookups could fill the queue.
   assign committed = {1'b0, queue_count} + (QCNT_W + 1)'(lkp_vld_ff);
   assign req_ready = (committed < (QCNT_W + 1)'(QUEUE_DEPTH));
   assign accept    = req_valid && req_ready;

   // Saturate the length, drop code bits above it.
   assign len_sat = (code_length > LENGTH_FIELD_W'(LEN_LIMIT)) ?
                    LEN_W'(LEN_LIMIT) : LEN_W'(code_length);
   assign code_masked = code_bits[LEN_LIMIT-1:0] & ~({LEN_LIMIT{1'b1}} << len_sat);

   assign ram_raddr = (item_mode == MODE_FINISH) ? eof_ff : symbol;
   assign eof_in    = csr_wen ? csr_wdata : eof_ff;

   always_comb begin
      ram_wen    = 1'b0;
      lkp_vld_in = 1'b0;
      lkp_fin_in = lkp_fin_ff;
      if (accept) begin
         case (item_mode)
            MODE_LOAD: begin
               ram_wen = 1'b1;
            end
            MODE_ENCODE: begin
               lkp_vld_in = 1'b1;
               lkp_fin_in = 1'b0;
            end
            MODE_FINISH: begin
               lkp_vld_in = 1'b1;
               lkp_fin_in = 1'b1;
            end
            default: begin
               // unused kind: drop
            end
         endcase
      end
   end

   hcp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .wen   (ram_wen),
      .waddr (symbol),
      .wdata ({len_sat, code_masked}),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         eof_ff     <= '0;
         lkp_vld_ff <= 1'b0;
         lkp_fin_ff <= 1'b0;
      end else begin
         eof_ff     <= eof_in;
         lkp_vld_ff <= lkp_vld_in;
         lkp_fin_ff <= lkp_fin_in;
      end
   end

   assign push      = lkp_vld_ff;
   assign push_code = ram_rdata[LEN_LIMIT-1:0];
   assign push_len  = ram_rdata[ENTRY_W-1:LEN_LIMIT];
   assign push_fin  = lkp_fin_ff;

endmodule

[hdl/hcp_back.sv]
// Back end: bit accumulator that merges codes and emits bytes MSB first.
module hcp_back #(
   parameter int MAX_CODE_LEN = hcp_pkg::MAX_CODE_LEN_DEF,
   localparam int LEN_LIMIT = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32,
   localparam int LEN_W     = $clog2(LEN_LIMIT + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  logic [LEN_LIMIT-1:0]          q_code,
   input  logic [LEN_W-1:0]              q_len,
   input  logic                          q_fin,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [hcp_pkg::BYTE_W-1:0]    rsp_byte,
   output logic                          rsp_last
);

   import hcp_pkg::*;

   localparam int PEND_W = BYTE_W - 1;
   localparam int AW     = LEN_LIMIT + PEND_W;
   localparam int CW     = $clog2(AW + 1);

   // Accumulator is left aligned: valid bits at the top, zeros below.
   logic [AW-1:0]     acc_ff, acc_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              fin_ff, fin_in;
   logic              rsp_vld_ff, rsp_vld_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              busy;
   logic              emit;
   logic              full_byte;
   logic [CW-1:0]     sh;

   assign full_byte = (cnt_ff >= CW'(BYTE_W));
   assign busy      = fin_ff ? (cnt_ff != '0) : full_byte;
   assign q_pop     = q_valid && !busy;
   assign emit      = busy && (!rsp_vld_ff || rsp_ready);
   assign sh        = CW'(AW) - cnt_ff - CW'(q_len);

   always_comb begin
      acc_in      = acc_ff;
      cnt_in      = cnt_ff;
      fin_in      = fin_ff;
      rsp_byte_in = rsp_byte_ff;
      rsp_last_in = rsp_last_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_ready;
      if (q_pop) begin
         // place the code right under the pending bits
         acc_in = acc_ff | ({{PEND_W{1'b0}}, q_code} << sh);
         cnt_in = cnt_ff + CW'(q_len);
         fin_in = q_fin;
      end else if (emit) begin
         rsp_vld_in  = 1'b1;
         rsp_byte_in = acc_ff[AW-1 -: BYTE_W];
         rsp_last_in = fin_ff && (cnt_ff <= CW'(BYTE_W));
         acc_in      = acc_ff << BYTE_W;
         cnt_in      = full_byte ? cnt_ff - CW'(BYTE_W) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff     <= '0;
         cnt_ff     <= '0;
         fin_ff     <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         acc_ff     <= acc_in;
         cnt_ff     <= cnt_in;
         fin_ff     <= fin_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_byte  = rsp_byte_ff;
   assign rsp_last  = rsp_last_ff;

endmodule
